/* rtl/acd_pkg.sv */
// Shared types, constants and AES helper functions for the CTR_DRBG core.
package acd_pkg;

   localparam logic [1:0] KIND_INST = 2'd0;
   localparam logic [1:0] KIND_RESEED = 2'd1;
   localparam logic [1:0] KIND_GEN = 2'd2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [1:0] STATUS_RESEED = 2'd2;

   localparam int CountWidth = 49;

   // Controller commands to the datapath
   typedef struct packed {
      logic seed_write;    // store seed word
      logic clear_state;   // zero key and counter
      logic key_load;      // load key schedule from stored key
      logic blk_start;     // bump counter and start one block
      logic update_keep;   // keep block 0 of update
      logic update_commit; // xor second block, commit key and counter
      logic use_seed;      // update data is seed buffer, else zero
      logic count_one;     // reseed count to one
      logic count_inc;     // saturating increment
      logic save_ctr;      // write back generate counter
   } cmd_type;

   typedef struct packed {
      logic blk_done;
      logic reseed_needed;
   } stat_type;

   typedef logic [7:0] sbox_tbl_type [256];

   localparam sbox_tbl_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xt(input logic [7:0] x);
      xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a 128-bit block sits at bits 8*i+7..8*i
   function automatic logic [127:0] bump_ctr(input logic [127:0] c);
      logic [127:0] be;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) be[8*(15-i) +: 8] = c[8*i +: 8];
      be = be + 128'd1;
      for (int i = 0; i < 16; i++) r[8*i +: 8] = be[8*(15-i) +: 8];
      bump_ctr = r;
   endfunction

   // One AES round without the round-key add
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last_rnd);
      logic [127:0] o;
      logic [127:0] m;
      logic [7:0] a0, a1, a2, a3, t;
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++)
            o[8*(i+4*c) +: 8] = SBOX[s[8*(i+4*((c+i)%4)) +: 8]];
      m = o;
      for (int c = 0; c < 4; c++) begin
         a0 = o[8*(4*c) +: 8];
         a1 = o[8*(4*c+1) +: 8];
         a2 = o[8*(4*c+2) +: 8];
         a3 = o[8*(4*c+3) +: 8];
         t = a0 ^ a1 ^ a2 ^ a3;
         m[8*(4*c) +: 8] = a0 ^ t ^ xt(a0 ^ a1);
         m[8*(4*c+1) +: 8] = a1 ^ t ^ xt(a1 ^ a2);
         m[8*(4*c+2) +: 8] = a2 ^ t ^ xt(a2 ^ a3);
         m[8*(4*c+3) +: 8] = a3 ^ t ^ xt(a3 ^ a0);
      end
      aes_round = last_rnd ? o : m;
   endfunction

   // Next round key from the previous one
   function automatic logic [127:0] next_rk(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] t;
      logic [127:0] r;
      t[7:0] = SBOX[k[111:104]] ^ rc;
      t[15:8] = SBOX[k[119:112]];
      t[23:16] = SBOX[k[127:120]];
      t[31:24] = SBOX[k[103:96]];
      r[31:0] = k[31:0] ^ t;
      r[63:32] = k[63:32] ^ r[31:0];
      r[95:64] = k[95:64] ^ r[63:32];
      r[127:96] = k[127:96] ^ r[95:64];
      next_rk = r;
   endfunction

endpackage

/* rtl/acd_datapath.sv */
// Datapath: key, counter, seed buffer, reseed count and iterative AES round unit.
module acd_datapath
   import acd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [1:0]            seed_index,
   input  logic [63:0]           seed_data,
   input  logic [CountWidth-1:0] interval,
   output logic [127:0]          blk_out
);

   logic [127:0] key_ff, key_in;
   logic [127:0] ctr_ff, ctr_in;
   logic [127:0] work_ctr_ff;
   logic [255:0] seed_ff;
   logic [CountWidth-1:0] count_ff;
   logic [127:0] st_ff, rk_ff, rk0_ff, keep_ff;
   logic [7:0] rc_ff;
   logic [3:0] rnd_ff;
   logic busy_ff;
   logic [127:0] nrk, bumped, upd_lo, upd_hi;

   assign nrk = next_rk(rk_ff, rc_ff);
   assign bumped = bump_ctr(work_ctr_ff);
   assign blk_out = st_ff;
   assign stat.blk_done = busy_ff && (rnd_ff == 4'd10);
   assign stat.reseed_needed = count_ff > interval;
   assign upd_lo = keep_ff ^ (cmd.use_seed ? seed_ff[127:0] : 128'd0);
   assign upd_hi = st_ff ^ (cmd.use_seed ? seed_ff[255:128] : 128'd0);

   // Select committed key and counter
   always_comb begin
      key_in = key_ff;
      ctr_in = ctr_ff;
      if (cmd.clear_state) begin
         key_in = '0;
         ctr_in = '0;
      end else if (cmd.update_commit) begin
         key_in = upd_lo;
         ctr_in = upd_hi;
      end else if (cmd.save_ctr) begin
         ctr_in = work_ctr_ff;
      end
   end

   // Hold committed state and the reseed count
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         ctr_ff <= '0;
         count_ff <= '1;
      end else begin
         key_ff <= key_in;
         ctr_ff <= ctr_in;
         if (cmd.count_one) count_ff <= CountWidth'(1);
         else if (cmd.count_inc && count_ff != '1) count_ff <= count_ff + 1'b1;
      end
   end

   // Store seed words
   always_ff @(posedge clock) begin
      if (cmd.seed_write) seed_ff[64*seed_index +: 64] <= seed_data;
   end

   // Run one round per cycle; the round key is expanded alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rnd_ff <= '0;
      end else if (cmd.blk_start) begin
         busy_ff <= 1'b1;
         rnd_ff <= 4'd0;
      end else if (busy_ff) begin
         if (rnd_ff == 4'd10) busy_ff <= 1'b0;
         else rnd_ff <= rnd_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.key_load) begin
         rk0_ff <= key_ff;
         work_ctr_ff <= ctr_ff;
      end
      if (cmd.update_keep) keep_ff <= st_ff;
      if (cmd.blk_start) begin
         work_ctr_ff <= bumped;
         st_ff <= bumped ^ rk0_ff;
         rk_ff <= rk0_ff;
         rc_ff <= 8'h01;
      end else if (busy_ff && rnd_ff != 4'd10) begin
         st_ff <= aes_round(st_ff, rnd_ff == 4'd9) ^ nrk;
         rk_ff <= nrk;
         rc_ff <= xt(rc_ff);
      end
   end

endmodule

/* rtl/acd_ctrl.sv */
// Controller state machine sequencing seeding, generate and update.
module acd_ctrl
   import acd_pkg::*;
#(
   parameter int MaxBytes = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_chunk_index,
   input  logic [9:0]  req_request_bytes,
   output cmd_type     cmd,
   input  stat_type    stat,
   input  logic [127:0] blk,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_data_word,
   output logic [3:0]  rsp_valid_bytes,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_LOAD  = 9'b000000010,
      S_GBLK  = 9'b000000100,
      S_GWAIT = 9'b000001000,
      S_EMIT  = 9'b000010000,
      S_ULOAD = 9'b000100000,
      S_U0    = 9'b001000000,
      S_U1    = 9'b010000000,
      S_ERR   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic gen_ff;          // generate, else seed update
   logic [9:0] left_ff;   // bytes still to send
   logic [127:0] blkbuf_ff;
   logic half_ff;
   logic [1:0] err_ff;
   logic ublk_ff;         // start of an update block
   logic acc, emit_go;
   logic [3:0] cnt;
   logic [63:0] word, mask;

   assign acc = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign emit_go = !rsp_stall;
   assign cnt = (left_ff >= 10'd8) ? 4'd8 : 4'(left_ff);
   assign word = half_ff ? blkbuf_ff[127:64] : blkbuf_ff[63:0];
   always_comb begin
      for (int b = 0; b < 8; b++) mask[8*b +: 8] = (4'(b) < cnt) ? 8'hff : 8'h00;
   end

   // Drive result ports
   assign rsp_valid = (state_ff == S_EMIT) || (state_ff == S_ERR);
   assign rsp_data_word = (state_ff == S_EMIT) ? (word & mask) : 64'd0;
   assign rsp_valid_bytes = (state_ff == S_EMIT) ? cnt : 4'd0;
   assign rsp_status = (state_ff == S_ERR) ? err_ff : STATUS_OK;
   assign rsp_last = (state_ff == S_ERR) || (left_ff <= 10'd8);

   // Decode commands and next state
   always_comb begin
      cmd = '0;
      state_in = state_ff;
      cmd.use_seed = !gen_ff;
      cmd.blk_start = ublk_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (acc && (req_kind == KIND_INST || req_kind == KIND_RESEED)) begin
               cmd.seed_write = 1'b1;
               if (req_chunk_index == 2'd3) begin
                  cmd.clear_state = (req_kind == KIND_INST);
                  state_in = S_ULOAD;
               end
            end else if (acc && req_kind == KIND_GEN) begin
               if (req_request_bytes > 10'(MaxBytes) || stat.reseed_needed) state_in = S_ERR;
               else state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.key_load = 1'b1;
            state_in = (left_ff == 10'd0) ? S_EMIT : S_GBLK;
         end
         S_GBLK: begin
            cmd.blk_start = 1'b1;
            state_in = S_GWAIT;
         end
         S_GWAIT: if (stat.blk_done) state_in = S_EMIT;
         S_EMIT: begin
            if (emit_go) begin
               if (left_ff <= 10'd8) begin
                  cmd.save_ctr = 1'b1;
                  state_in = S_ULOAD;
               end else if (half_ff) state_in = S_GBLK;
            end
         end
         S_ULOAD: begin
            cmd.key_load = 1'b1;
            state_in = S_U0;
         end
         S_U0: begin
            if (stat.blk_done) begin
               cmd.update_keep = 1'b1;
               state_in = S_U1;
            end
         end
         S_U1: begin
            if (stat.blk_done) begin
               cmd.update_commit = 1'b1;
               cmd.count_one = !gen_ff;
               cmd.count_inc = gen_ff;
               state_in = S_IDLE;
            end
         end
         S_ERR: if (emit_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Start update blocks: one after the load, one after the first completes
   always_ff @(posedge clock) begin
      if (reset) ublk_ff <= 1'b0;
      else ublk_ff <= (state_ff == S_ULOAD) || (state_ff == S_U0 && stat.blk_done);
   end

   // Advance state and bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gen_ff <= 1'b0;
         left_ff <= '0;
         half_ff <= 1'b0;
         err_ff <= STATUS_OK;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && acc) begin
            gen_ff <= (req_kind == KIND_GEN);
            left_ff <= req_request_bytes;
            half_ff <= 1'b0;
            err_ff <= (req_request_bytes > 10'(MaxBytes)) ? STATUS_TOO_LARGE : STATUS_RESEED;
         end
         if (state_ff == S_EMIT && emit_go && left_ff > 10'd8) begin
            left_ff <= left_ff - 10'd8;
            half_ff <= !half_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_GWAIT && stat.blk_done) blkbuf_ff <= blk;
   end

   // Results come only from generate requests
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERR) |-> rsp_last) else $error("error result without last");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("input taken while busy");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && left_ff != 10'd0) |-> (rsp_valid_bytes != 4'd0))
      else $error("empty word before end");

   assign_cmd_out: assert property (@(posedge clock) disable iff (reset)
      cmd.update_commit |-> (state_ff == S_U1)) else $error("commit outside update");

endmodule

/* rtl/aes128_ctr_drbg_core.sv */
// Top level of the AES-128 CTR_DRBG core.
// A seed word with chunk index 0 to 2 is taken and stored; the word that completes a seed
// runs one update: a key load and two AES blocks on the single round unit, and no new
// transfer is taken until the update is done. A generate request works through its 16-byte
// blocks in turn (start, ten rounds, completion, result words) after a load step, and ends
// with the same update; the shared iterative AES round core sets its throughput. Each block
// gives up to two results on consecutive cycles while the output side does not stall, then a
// pause while the next block is computed. A rejected request gives its one result in the
// cycle after the transfer. The user must write reseed_interval through csr_write_enable /
// csr_write_data only while the core is idle; the core itself does not enforce this.
module aes128_ctr_drbg_core
   import acd_pkg::*;
#(
   parameter int MAX_REQUEST_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [48:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_seed_word,
   input  logic [1:0]  req_chunk_index,
   input  logic [9:0]  req_request_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_data_word,
   output logic [3:0]  rsp_valid_bytes,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   cmd_type cmd;
   stat_type stat;
   logic [127:0] blk;
   logic [48:0] interval_ff;

   // Hold the reseed interval
   always_ff @(posedge clock) begin
      if (reset) interval_ff <= 49'h1_0000_0000_0000;
      else if (csr_write_enable) interval_ff <= csr_write_data;
   end

   acd_ctrl #(.MaxBytes(MAX_REQUEST_BYTES)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_chunk_index,
      .req_request_bytes, .cmd, .stat, .blk, .rsp_valid, .rsp_stall,
      .rsp_data_word, .rsp_valid_bytes, .rsp_status, .rsp_last
   );

   acd_datapath u_dp (
      .clock, .reset, .cmd, .stat, .seed_index(req_chunk_index),
      .seed_data(req_seed_word), .interval(interval_ff), .blk_out(blk)
   );

endmodule
